// File: hw/rtl/assert_macros.svh
// Assertion macros, used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MWS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mws_pkg.sv
// Shared types, operation codes and constants of the Metropolis walker step block.
package mws_pkg;

  localparam int IN_W  = 72;
  localparam int OUT_W = 296;
  localparam int EXP_BITS = 20;

  localparam logic [1:0] OP_STEP  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] REG_ALPHA  = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_ORIGIN = 2'd2;
  localparam logic [1:0] REG_BPU    = 2'd3;

  localparam logic [17:0] ALPHA_RST  = 18'd32768;
  localparam logic [15:0] STEP_RST   = 16'd4096;
  localparam logic [23:0] ORIGIN_RST = 24'hF60000;
  localparam logic [15:0] BPU_RST    = 16'd2560;

  typedef struct packed {
    logic clear;
    logic inc_step;
    logic inc_accept;
    logic energy_valid;
  } acc_ctl_t;

  typedef struct packed {
    logic [63:0] energy_sum;
    logic [62:0] energy_sq_sum;
    logic [31:0] accept_count;
    logic [31:0] step_count;
  } acc_stat_t;

  // exp(-2^(i-16)) in unsigned Q0.32.
  function automatic logic [31:0] exp_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd4294901760;
      5'd1:    v = 32'd4294836226;
      5'd2:    v = 32'd4294705160;
      5'd3:    v = 32'd4294443040;
      5'd4:    v = 32'd4293918848;
      5'd5:    v = 32'd4292870656;
      5'd6:    v = 32'd4290775039;
      5'd7:    v = 32'd4286586875;
      5'd8:    v = 32'd4278222805;
      5'd9:    v = 32'd4261543595;
      5'd10:   v = 32'd4228380000;
      5'd11:   v = 32'd4162825044;
      5'd12:   v = 32'd4034748382;
      5'd13:   v = 32'd3790295336;
      5'd14:   v = 32'd3344923893;
      5'd15:   v = 32'd2605029347;
      5'd16:   v = 32'd1580030169;
      5'd17:   v = 32'd581260616;
      5'd18:   v = 32'd78665068;
      5'd19:   v = 32'd1440801;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/mws_exp_unit.sv
// Iterative acceptance-ratio unit: one table factor per set exponent bit.
module mws_exp_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [19:0] e_bits,
  input  logic [15:0] uniform,
  output logic        busy,
  output logic        done,
  output logic        accept
);

  logic        run;
  logic        fin;
  logic [4:0]  idx;
  logic [19:0] bits;
  logic [15:0] u;
  logic [31:0] r;
  logic        r_full;
  logic [31:0] tab;
  logic [63:0] prod;
  logic [63:0] prod_rnd;
  logic [31:0] r_next;
  logic [32:0] r_rnd;

  assign tab      = mws_pkg::exp_entry(idx);
  assign prod     = r * tab;
  assign prod_rnd = prod + 64'h0000_0000_8000_0000;
  // The first factor taken replaces the implicit 1.0 exactly.
  assign r_next   = r_full ? tab : prod_rnd[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= !start && run && (idx == 5'(mws_pkg::EXP_BITS - 1));
      if (start) begin
        run    <= 1'b1;
        idx    <= 5'd0;
        r_full <= 1'b1;
        bits   <= e_bits;
        u      <= uniform;
      end else if (run) begin
        if (bits[idx]) begin
          r      <= r_next;
          r_full <= 1'b0;
        end
        if (idx == 5'(mws_pkg::EXP_BITS - 1)) begin
          run <= 1'b0;
        end
        idx <= idx + 5'd1;
      end
    end
  end

  assign r_rnd  = {1'b0, r} + 33'd32768;
  assign busy   = run;
  assign done   = fin;
  assign accept = r_rnd[32:16] > {1'b0, u};

endmodule

// File: hw/rtl/mws_accum.sv
// Saturating energy sums and move counters.
module mws_accum (
  input  logic                clk,
  input  logic                rst,
  input  mws_pkg::acc_ctl_t   ctl,
  input  logic signed [31:0]  energy,
  output mws_pkg::acc_stat_t  stat
);

  logic signed [63:0] esum;
  logic [62:0]        sqsum;
  logic [31:0]        acnt;
  logic [31:0]        scnt;
  logic [63:0]        sq;
  logic               sq_v;
  logic signed [64:0] esum_ext;
  logic [31:0]        mag;
  logic [63:0]        sq_c;
  logic [63:0]        sqsum_ext;

  assign esum_ext  = {esum[63], esum} + {{33{energy[31]}}, energy};
  assign mag       = energy[31] ? (~energy + 32'd1) : energy;
  assign sq_c      = mag * mag;
  assign sqsum_ext = {1'b0, sqsum} + sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      esum  <= '0;
      sqsum <= '0;
      acnt  <= '0;
      scnt  <= '0;
      sq_v  <= 1'b0;
    end else begin
      sq_v <= !ctl.clear && ctl.energy_valid;
      if (ctl.clear) begin
        esum  <= '0;
        sqsum <= '0;
        acnt  <= '0;
        scnt  <= '0;
      end else begin
        if (ctl.inc_step && !(&scnt)) begin
          scnt <= scnt + 32'd1;
        end
        if (ctl.inc_accept && !(&acnt)) begin
          acnt <= acnt + 32'd1;
        end
        if (ctl.energy_valid) begin
          if (esum_ext[64] != esum_ext[63]) begin
            esum <= esum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            esum <= esum_ext[63:0];
          end
          sq <= sq_c;
        end
        if (sq_v) begin
          sqsum <= sqsum_ext[63] ? {63{1'b1}} : sqsum_ext[62:0];
        end
      end
    end
  end

  assign stat.energy_sum    = esum;
  assign stat.energy_sq_sum = sqsum;
  assign stat.accept_count  = acnt;
  assign stat.step_count    = scnt;

endmodule

// File: hw/rtl/metropolis_walker_step.sv
// Top level of the Metropolis walker step block: memories, sequencer and datapath.
//
//   channel  direction  payload (lowest bits first)
//   s_*      in         tdata: walker_index, gauss_sample, uniform_sample,
//                              load_position, bin_select; tuser: op
//   m_*      out        tdata: accepted, position, local_energy, bin_index,
//                              bin_hit, bin_count, energy_sum, energy_sq_sum,
//                              accept_count, step_count, zero fill
//   cfg_*    in         cfg_index selects alpha, step_size, hist_origin, bins_per_unit
//
// One transaction is worked on at a time. A step settles the ratio by the exponent's
// sign or range where it can, and else runs the 20-step ratio loop of the exponent unit.
// Load and invalid indexes go straight to the result, a bin read through the read state,
// and a clear reruns the memory sweep over max(NUM_WALKERS, NUM_BINS) addresses, zeroing
// only the histogram. After reset that sweep zeroes both memories; s_tready stays
// low during it. A result waits in the output register while m_tready is low; the next
// transaction is processed meanwhile up to its result.
`include "assert_macros.svh"

module metropolis_walker_step #(
  parameter int NUM_WALKERS = 256,
  parameter int NUM_BINS    = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // walker_index, gauss_sample, uniform_sample, load_position, bin_select
  input  logic [mws_pkg::IN_W-1:0]     s_tdata,
  // op
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // accepted, position, local_energy, bin_index, bin_hit, bin_count,
  // energy_sum, energy_sq_sum, accept_count, step_count
  output logic [mws_pkg::OUT_W-1:0]    m_tdata,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [23:0]                  cfg_wdata
);

  localparam int WIW  = (NUM_WALKERS > 1) ? $clog2(NUM_WALKERS) : 1;
  localparam int BIW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int MAXD = (NUM_WALKERS > NUM_BINS) ? NUM_WALKERS : NUM_BINS;
  localparam int CW   = $clog2(MAXD + 1);

  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_RD   = 5'd2;
  localparam logic [4:0] ST_T0   = 5'd3;
  localparam logic [4:0] ST_T1   = 5'd4;
  localparam logic [4:0] ST_T2   = 5'd5;
  localparam logic [4:0] ST_T3   = 5'd6;
  localparam logic [4:0] ST_T4   = 5'd7;
  localparam logic [4:0] ST_T5   = 5'd8;
  localparam logic [4:0] ST_EXP  = 5'd9;
  localparam logic [4:0] ST_DEC  = 5'd10;
  localparam logic [4:0] ST_E1   = 5'd11;
  localparam logic [4:0] ST_E2   = 5'd12;
  localparam logic [4:0] ST_E3   = 5'd13;
  localparam logic [4:0] ST_E4   = 5'd14;
  localparam logic [4:0] ST_E5   = 5'd15;
  localparam logic [4:0] ST_E6   = 5'd16;
  localparam logic [4:0] ST_FIN  = 5'd17;

  // Configuration registers.
  logic [17:0]        alpha;
  logic [15:0]        step_size;
  logic signed [23:0] origin;
  logic [15:0]        bpu;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= mws_pkg::ALPHA_RST;
      step_size <= mws_pkg::STEP_RST;
      origin    <= mws_pkg::ORIGIN_RST;
      bpu       <= mws_pkg::BPU_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mws_pkg::REG_ALPHA:  alpha     <= cfg_wdata[17:0];
        mws_pkg::REG_STEP:   step_size <= cfg_wdata[15:0];
        mws_pkg::REG_ORIGIN: origin    <= cfg_wdata;
        mws_pkg::REG_BPU:    bpu       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Input unpacking.
  logic [1:0]         in_op;
  logic [7:0]         in_widx;
  logic signed [15:0] in_g;
  logic [15:0]        in_u;
  logic signed [23:0] in_ld;
  logic [7:0]         in_sel;
  logic [12:0]        in_widx13;
  logic [12:0]        in_sel13;
  logic               in_widx_ok;
  logic               in_sel_ok;

  assign in_op      = s_tuser;
  assign in_widx    = s_tdata[7:0];
  assign in_g       = s_tdata[23:8];
  assign in_u       = s_tdata[39:24];
  assign in_ld      = s_tdata[63:40];
  assign in_sel     = s_tdata[71:64];
  assign in_widx13  = 13'(in_widx);
  assign in_sel13   = 13'(in_sel);
  assign in_widx_ok = in_widx13 < 13'(NUM_WALKERS);
  assign in_sel_ok  = in_sel13 < 13'(NUM_BINS);

  logic [4:0]    state;
  logic          in_acc;
  logic [CW-1:0] cnt;
  logic          clr_walk;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // Walker position memory: one write port, one registered read port.
  logic signed [23:0] wmem [NUM_WALKERS];
  logic               w_we;
  logic [WIW-1:0]     w_waddr;
  logic signed [23:0] w_wdata;
  logic [WIW-1:0]     w_raddr;
  logic signed [23:0] w_rdata;

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rdata <= wmem[w_raddr];
  end

  // Histogram memory.
  logic [31:0]    hmem [NUM_BINS];
  logic           h_we;
  logic [BIW-1:0] h_waddr;
  logic [31:0]    h_wdata;
  logic [BIW-1:0] h_raddr;
  logic [31:0]    h_rdata;

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    h_rdata <= hmem[h_raddr];
  end

  // Datapath registers.
  logic [WIW-1:0]     widx;
  logic signed [15:0] g;
  logic [15:0]        u;
  logic signed [23:0] x;
  logic signed [32:0] psg;
  logic signed [23:0] xt;
  logic [46:0]        xsq;
  logic [46:0]        xtsq;
  logic signed [31:0] d;
  logic signed [50:0] ed;
  logic               acc_r;
  logic signed [24:0] diffb;
  logic [46:0]        psq;
  logic [35:0]        aa;
  logic signed [41:0] bp;
  logic [30:0]        q;
  logic signed [22:0] c;
  logic signed [16:0] bin_s;
  logic signed [54:0] qc;
  logic signed [31:0] en;

  // Result fields of the transaction in progress.
  logic               res_acc;
  logic signed [23:0] res_pos;
  logic signed [31:0] res_en;
  logic [7:0]         res_bidx;
  logic               res_bhit;
  logic [31:0]        res_bcnt;

  // Combinational datapath pieces feeding the sequencer states.
  logic signed [32:0] psg_rnd;
  logic signed [24:0] rsg;
  logic signed [25:0] xt_sum;
  logic signed [47:0] xsq_c;
  logic signed [47:0] xtsq_c;
  logic signed [47:0] dd;
  logic signed [50:0] ed_c;
  logic signed [50:0] ev;
  logic               e_le0;
  logic               e_big;
  logic signed [23:0] pos_n;
  logic signed [47:0] psq_c;
  logic [35:0]        aa_c;
  logic signed [41:0] bp_c;
  logic [46:0]        qv;
  logic signed [38:0] cv;
  logic signed [16:0] bin_c;
  logic               hit_c;
  logic signed [54:0] qc_c;
  logic signed [55:0] ev2;
  logic signed [39:0] eh;
  logic [31:0]        hcnt_inc;

  assign psg_rnd  = psg + 33'sd128;
  assign rsg      = psg_rnd[32:8];
  assign xt_sum   = {{2{x[23]}}, x} + {rsg[24], rsg};
  assign xsq_c    = x * x;
  assign xtsq_c   = xt * xt;
  assign dd       = $signed({1'b0, xtsq}) - $signed({1'b0, xsq}) + 48'sd32768;
  assign ed_c     = d * $signed({1'b0, alpha});
  // Exponent of the ratio: rnd(2 * alpha * d, 16) is ev >>> 15.
  assign ev       = ed + 51'sd16384;
  assign e_le0    = ev[50] || (ev[50:15] == 36'd0);
  assign e_big    = |ev[49:35];
  assign pos_n    = acc_r ? xt : x;
  assign psq_c    = res_pos * res_pos;
  assign aa_c     = alpha * alpha;
  assign bp_c     = diffb * $signed({1'b0, bpu});
  assign qv       = psq + 47'd32768;
  assign cv       = 39'sd2147483648 - $signed({2'b00, aa, 1'b0}) + 39'sd32768;
  assign bin_c    = bp[40:24];
  // Bins below the origin come out negative and are skipped like those past the top.
  assign hit_c    = !bin_c[16] && (bin_c[15:0] < 16'(NUM_BINS));
  assign qc_c     = $signed({1'b0, q}) * c;
  assign ev2      = $signed({22'd0, alpha, 16'd0}) + qc + 56'sd32768;
  assign eh       = ev2[55:16];
  assign hcnt_inc = (&h_rdata) ? h_rdata : h_rdata + 32'd1;

  // Exponent unit and accumulators.
  logic exp_start;
  logic exp_busy;
  logic exp_done;
  logic exp_accept;

  assign exp_start = (state == ST_T5) && !e_le0 && !e_big;

  mws_exp_unit u_exp (
    .clk     (clk),
    .rst     (rst),
    .start   (exp_start),
    .e_bits  (ev[34:15]),
    .uniform (u),
    .busy    (exp_busy),
    .done    (exp_done),
    .accept  (exp_accept)
  );

  mws_pkg::acc_ctl_t  actl;
  mws_pkg::acc_stat_t astat;

  assign actl.clear        = in_acc && (in_op == mws_pkg::OP_CLEAR);
  assign actl.inc_step     = (state == ST_DEC);
  assign actl.inc_accept   = (state == ST_DEC) && acc_r;
  assign actl.energy_valid = (state == ST_E5);

  mws_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctl    (actl),
    .energy (en),
    .stat   (astat)
  );

  // Memory port steering.
  always_comb begin
    w_we    = 1'b0;
    w_waddr = widx;
    w_wdata = xt;
    h_we    = 1'b0;
    h_waddr = bin_s[BIW-1:0];
    h_wdata = hcnt_inc;
    w_raddr = in_widx13[WIW-1:0];
    h_raddr = (state == ST_IDLE) ? in_sel13[BIW-1:0] : bin_c[BIW-1:0];
    case (state)
      ST_CLR: begin
        w_we    = clr_walk && (cnt < CW'(NUM_WALKERS));
        w_waddr = cnt[WIW-1:0];
        w_wdata = '0;
        h_we    = cnt < CW'(NUM_BINS);
        h_waddr = cnt[BIW-1:0];
        h_wdata = '0;
      end
      ST_IDLE: begin
        w_we    = in_acc && (in_op == mws_pkg::OP_LOAD) && in_widx_ok;
        w_waddr = in_widx13[WIW-1:0];
        w_wdata = in_ld;
      end
      ST_DEC: begin
        w_we = acc_r;
      end
      ST_E3: begin
        h_we = res_bhit;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      cnt      <= '0;
      clr_walk <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      // The finish state reloads the output register itself when it is taken.
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(MAXD - 1)) begin
            // The sweep after reset returns to idle; a clear op still owes a result.
            state    <= clr_walk ? ST_IDLE : ST_FIN;
            clr_walk <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            res_acc  <= 1'b0;
            res_pos  <= ((in_op == mws_pkg::OP_LOAD) && in_widx_ok) ? in_ld : 24'sd0;
            res_en   <= '0;
            res_bidx <= (in_op == mws_pkg::OP_READ) ? in_sel : 8'd0;
            res_bhit <= 1'b0;
            res_bcnt <= '0;
            widx     <= in_widx13[WIW-1:0];
            g        <= in_g;
            u        <= in_u;
            case (in_op)
              mws_pkg::OP_STEP: begin
                state <= in_widx_ok ? ST_T0 : ST_FIN;
              end
              mws_pkg::OP_LOAD: begin
                state <= ST_FIN;
              end
              mws_pkg::OP_CLEAR: begin
                cnt   <= '0;
                state <= ST_CLR;
              end
              mws_pkg::OP_READ: begin
                state <= in_sel_ok ? ST_RD : ST_FIN;
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_RD: begin
          res_bhit <= 1'b1;
          res_bcnt <= h_rdata;
          state    <= ST_FIN;
        end
        ST_T0: begin
          x     <= w_rdata;
          psg   <= $signed({1'b0, step_size}) * g;
          state <= ST_T1;
        end
        ST_T1: begin
          if (!xt_sum[25] && (xt_sum[24:23] != 2'b00)) begin
            xt <= 24'sh7FFFFF;
          end else if (xt_sum[25] && (xt_sum[24:23] != 2'b11)) begin
            xt <= 24'sh800000;
          end else begin
            xt <= xt_sum[23:0];
          end
          state <= ST_T2;
        end
        ST_T2: begin
          xsq   <= xsq_c[46:0];
          xtsq  <= xtsq_c[46:0];
          state <= ST_T3;
        end
        ST_T3: begin
          d     <= dd[47:16];
          state <= ST_T4;
        end
        ST_T4: begin
          ed    <= ed_c;
          state <= ST_T5;
        end
        ST_T5: begin
          // A downhill move is always taken; a very steep uphill one never is.
          if (e_le0) begin
            acc_r <= 1'b1;
            state <= ST_DEC;
          end else if (e_big) begin
            acc_r <= 1'b0;
            state <= ST_DEC;
          end else begin
            state <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (exp_done) begin
            acc_r <= exp_accept;
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          res_acc <= acc_r;
          res_pos <= pos_n;
          diffb   <= {pos_n[23], pos_n} - {origin[23], origin};
          state   <= ST_E1;
        end
        ST_E1: begin
          psq   <= psq_c[46:0];
          aa    <= aa_c;
          bp    <= bp_c;
          state <= ST_E2;
        end
        ST_E2: begin
          q        <= qv[46:16];
          c        <= cv[38:16];
          bin_s    <= bin_c;
          res_bhit <= hit_c;
          res_bidx <= hit_c ? bin_c[7:0] : 8'd0;
          state    <= ST_E3;
        end
        ST_E3: begin
          qc <= qc_c;
          if (res_bhit) begin
            res_bcnt <= hcnt_inc;
          end
          state <= ST_E4;
        end
        ST_E4: begin
          if (eh[39:31] == {9{eh[31]}}) begin
            en <= eh[31:0];
          end else begin
            en <= eh[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end
          state <= ST_E5;
        end
        ST_E5: begin
          res_en <= en;
          state  <= ST_E6;
        end
        ST_E6: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, astat.step_count, astat.accept_count,
                         astat.energy_sq_sum, astat.energy_sum, res_bcnt, res_bhit,
                         res_bidx, res_en, res_pos, res_acc};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MWS_ASSERT_SAME(a_exp_only_in_wait, exp_busy, state == ST_EXP, "exponent unit runs outside its wait state")
  `MWS_ASSERT_SAME(a_accepts_within_steps, 1'b1, astat.accept_count <= astat.step_count, "more accepted moves than steps")
  `MWS_ASSERT_SAME(a_result_from_fin, $rose(m_tvalid), $past(state) == ST_FIN, "result raised outside the finish state")
  `MWS_ASSERT_NEXT(a_step_blocks_input, in_acc && (in_op == mws_pkg::OP_STEP), !s_tready, "input taken during a step")

endmodule

// File: tb/tb_metropolis_walker_step.sv
// Self-checking testbench for the Metropolis walker step block.
`timescale 1ns / 100ps

module tb_metropolis_walker_step;

  localparam int NWALK = 256;
  localparam int NBIN = 256;
  // Cycles with no transaction on either side before the run is abandoned. A clear
  // sweeps the histogram and the post-reset sweep clears both memories, so this
  // sits well above both of them.
  localparam int STALL_LIMIT = 6000;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    bit          accepted;
    bit [23:0]   position;
    bit [31:0]   local_energy;
    bit [7:0]    bin_index;
    bit          bin_hit;
    bit [31:0]   bin_count;
    bit [63:0]   energy_sum;
    bit [62:0]   energy_sq_sum;
    bit [31:0]   accept_count;
    bit [31:0]   step_count;
  } step_result_t;

  // exp(-2^(i-16)) in Q0.32, one entry per bit of the exponent.
  localparam bit [31:0] EXP_LUT [20] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295336, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260616,  32'd78665068,   32'd1440801
  };

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  // walker_index, gauss_sample, uniform_sample, load_position, bin_select
  logic [mws_pkg::IN_W-1:0]  s_tdata;
  // op
  logic [1:0]                s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  // accepted, position, local_energy, bin_index, bin_hit, bin_count,
  // energy_sum, energy_sq_sum, accept_count, step_count, zero fill
  logic [mws_pkg::OUT_W-1:0] m_tdata;
  logic                      cfg_we;
  logic [1:0]                cfg_index;
  logic [23:0]               cfg_wdata;

  metropolis_walker_step #(
    .NUM_WALKERS(NWALK),
    .NUM_BINS(NBIN)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted copy of the block's registers and memories.
  longint     cur_alpha;
  longint     cur_step;
  longint     cur_origin;
  longint     cur_bpu;
  longint     walker_pos [NWALK];
  bit [31:0]  hist_count [NBIN];
  longint     energy_acc;
  bit [63:0]  energy_sq_acc;
  bit [31:0]  accept_cnt;
  bit [31:0]  step_cnt;

  step_result_t pending_results[$];
  int           errors;
  int           tx_idle_pct;
  int           rx_idle_pct;
  int           quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round half up, then floor: arithmetic shift of a signed value is a floor.
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic bit [31:0] sat_inc(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Metropolis acceptance test from the squared-position change.
  function automatic bit move_accepted(longint x, longint xt, bit [15:0] u);
    longint    d;
    longint    e;
    bit [63:0] ratio;
    d = round_shift(xt * xt - x * x, 16);
    e = round_shift(2 * cur_alpha * d, 16);
    if (e <= 0) return 1'b1;
    if (e >= (longint'(1) << 20)) return 1'b0;
    ratio = 64'd1 << 32;
    for (int i = 0; i < 20; i++)
      if (e[i]) ratio = (ratio * EXP_LUT[i] + (64'd1 << 31)) >> 32;
    return ((ratio + 64'd32768) >> 16) > {48'd0, u};
  endfunction

  function automatic longint energy_at(longint x);
    longint c;
    longint q;
    longint e;
    c = round_shift((longint'(1) << 31) - 2 * cur_alpha * cur_alpha, 16);
    q = round_shift(x * x, 16);
    e = round_shift(cur_alpha * 65536 + q * c, 16);
    if (e > 64'sd2147483647) e = 64'sd2147483647;
    if (e < -64'sd2147483648) e = -64'sd2147483648;
    return e;
  endfunction

  // Applies one transaction to the predicted state and returns the result it causes.
  function automatic step_result_t walker_predict(bit [1:0] op, bit [7:0] widx,
                                                  bit [15:0] g, bit [15:0] u,
                                                  bit [23:0] ld, bit [7:0] sel);
    step_result_t r;
    longint       x;
    longint       xt;
    longint       en;
    longint       b;
    bit [63:0]    sq;
    r = '{default: '0};
    if (op == mws_pkg::OP_STEP) begin
      x = walker_pos[widx];
      xt = x + round_shift(cur_step * longint'($signed(g)), 8);
      if (xt > 64'sd8388607) xt = 64'sd8388607;
      if (xt < -64'sd8388608) xt = -64'sd8388608;
      if (move_accepted(x, xt, u)) begin
        walker_pos[widx] = xt;
        accept_cnt = sat_inc(accept_cnt);
        r.accepted = 1'b1;
      end
      step_cnt = sat_inc(step_cnt);
      x = walker_pos[widx];
      en = energy_at(x);
      if (en > 0 && energy_acc > I64_MAX - en) energy_acc = I64_MAX;
      else if (en < 0 && energy_acc < I64_MIN - en) energy_acc = I64_MIN;
      else energy_acc = energy_acc + en;
      sq = 64'(en * en);
      if (energy_sq_acc > 64'(I64_MAX) - sq) energy_sq_acc = 64'(I64_MAX);
      else energy_sq_acc = energy_sq_acc + sq;
      b = ((x - cur_origin) * cur_bpu) >>> 24;
      r.position = x[23:0];
      r.local_energy = en[31:0];
      if (b >= 0 && b < NBIN) begin
        hist_count[b] = sat_inc(hist_count[b]);
        r.bin_index = b[7:0];
        r.bin_hit = 1'b1;
        r.bin_count = hist_count[b];
      end
    end else if (op == mws_pkg::OP_LOAD) begin
      walker_pos[widx] = longint'($signed(ld));
      r.position = ld;
    end else if (op == mws_pkg::OP_CLEAR) begin
      foreach (hist_count[i]) hist_count[i] = '0;
      energy_acc = 0;
      energy_sq_acc = '0;
      accept_cnt = '0;
      step_cnt = '0;
    end else begin
      r.bin_index = sel;
      r.bin_hit = 1'b1;
      r.bin_count = hist_count[sel];
    end
    r.energy_sum = energy_acc;
    r.energy_sq_sum = energy_sq_acc[62:0];
    r.accept_count = accept_cnt;
    r.step_count = step_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string field, bit [63:0] got, bit [63:0] want);
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  // Sends one transaction, honoring the current sender idle rate, and records
  // the expected result at the edge where it is taken.
  task automatic send_item(bit [1:0] op, bit [7:0] widx, bit [15:0] g, bit [15:0] u,
                           bit [23:0] ld, bit [7:0] sel);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {sel, ld, u, g, widx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(walker_predict(op, widx, g, u, ld, sel));
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [23:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mws_pkg::REG_ALPHA:  cur_alpha = longint'(value[17:0]);
      mws_pkg::REG_STEP:   cur_step = longint'(value[15:0]);
      mws_pkg::REG_ORIGIN: cur_origin = longint'($signed(value));
      default:             cur_bpu = longint'(value[15:0]);
    endcase
  endtask

  task automatic random_config();
    write_reg(mws_pkg::REG_ALPHA, 24'($urandom_range(0, 131071)));
    write_reg(mws_pkg::REG_STEP, 24'($urandom_range(256, 8192)));
    write_reg(mws_pkg::REG_ORIGIN, 24'(-int'($urandom_range(65536, 1310720))));
    write_reg(mws_pkg::REG_BPU, 24'($urandom_range(256, 5120)));
  endtask

  // Every field at its extremes, every operation, and reads of a bin before and after a clear.
  task automatic test_directed();
    send_item(mws_pkg::OP_READ, 8'd0, '0, '0, '0, 8'd0);
    send_item(mws_pkg::OP_LOAD, 8'd0, '0, '0, 24'h7FFFFF, 8'hFF);
    send_item(mws_pkg::OP_STEP, 8'd0, 16'h7FFF, 16'hFFFF, '0, '0);
    send_item(mws_pkg::OP_LOAD, 8'd255, '0, '0, 24'h800000, '0);
    send_item(mws_pkg::OP_STEP, 8'd255, 16'h8000, 16'd0, '0, '0);
    send_item(mws_pkg::OP_STEP, 8'd255, 16'h7FFF, 16'd0, '0, '0);
    send_item(mws_pkg::OP_STEP, 8'd1, 16'h1000, 16'hFFFF, '0, '0);
    send_item(mws_pkg::OP_STEP, 8'd1, 16'h1000, 16'd0, '0, '0);
    send_item(mws_pkg::OP_LOAD, 8'd2, '0, '0, 24'hF50000, '0);
    send_item(mws_pkg::OP_STEP, 8'd2, 16'd0, 16'd0, '0, '0);
    send_item(mws_pkg::OP_READ, 8'd0, '0, '0, '0, 8'd255);
    send_item(mws_pkg::OP_READ, 8'd0, '0, '0, '0, 8'd100);
    send_item(mws_pkg::OP_CLEAR, 8'hA5, 16'h5A5A, 16'hA5A5, 24'h5A5A5A, 8'h5A);
    send_item(mws_pkg::OP_READ, 8'd0, '0, '0, '0, 8'd100);
    send_item(mws_pkg::OP_STEP, 8'd1, 16'hFFFF, 16'h8000, '0, '0);
  endtask

  // Large positions with no trial move pile up energy squares until that sum saturates.
  task automatic test_saturation();
    write_reg(mws_pkg::REG_ALPHA, 24'd0);
    send_item(mws_pkg::OP_LOAD, 8'd7, '0, '0, 24'h7FFFFF, '0);
    for (int i = 0; i < 40; i++)
      send_item(mws_pkg::OP_STEP, 8'd7, 16'd0, 16'hFFFF, '0, '0);
    send_item(mws_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
  endtask

  // Extreme register settings, each with a short run of steps.
  task automatic test_config_extremes();
    bit [23:0] settings [4][3];
    settings = '{'{24'd0, 24'h3FFFF, 24'd65536},
                 '{24'd0, 24'hFFFF, 24'd4096},
                 '{24'h800000, 24'h7FFFFF, 24'hF60000},
                 '{24'd0, 24'd1, 24'hFFFF}};
    for (int r = 0; r < 4; r++)
      for (int k = 0; k < 3; k++) begin
        write_reg(2'(r), settings[r][k]);
        for (int i = 0; i < 4; i++)
          send_item(mws_pkg::OP_STEP, 8'($urandom_range(0, 3)), 16'($urandom),
                    16'($urandom), '0, '0);
        send_item(mws_pkg::OP_READ, '0, '0, '0, '0, 8'($urandom));
      end
    write_reg(mws_pkg::REG_ALPHA, 24'(mws_pkg::ALPHA_RST));
    write_reg(mws_pkg::REG_STEP, 24'(mws_pkg::STEP_RST));
    write_reg(mws_pkg::REG_ORIGIN, mws_pkg::ORIGIN_RST);
    write_reg(mws_pkg::REG_BPU, 24'(mws_pkg::BPU_RST));
  endtask

  // Mostly steps of moderate size on a few walkers, with loads, reads, rare clears,
  // and now and then a full-range sample.
  task automatic test_random(int count);
    int        pick;
    bit [1:0]  op;
    bit [7:0]  widx;
    bit [15:0] g;
    bit [23:0] ld;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      widx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      g = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 8191)) - 4096);
      ld = ($urandom_range(9) == 0) ? 24'($urandom)
                                    : 24'(int'($urandom_range(0, 1310720)) - 655360);
      if (pick < 70) op = mws_pkg::OP_STEP;
      else if (pick < 84) op = mws_pkg::OP_LOAD;
      else if (pick < 98) op = mws_pkg::OP_READ;
      else op = mws_pkg::OP_CLEAR;
      send_item(op, widx, g, 16'($urandom), ld, 8'($urandom));
      if (n == count / 2) drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = mws_pkg::OP_STEP;
    cfg_we = 1'b0;
    cfg_index = mws_pkg::REG_ALPHA;
    cfg_wdata = '0;
    errors = 0;
    tx_idle_pct = 25;
    rx_idle_pct = 68;
    cur_alpha = longint'(mws_pkg::ALPHA_RST);
    cur_step = longint'(mws_pkg::STEP_RST);
    cur_origin = longint'($signed(mws_pkg::ORIGIN_RST));
    cur_bpu = longint'(mws_pkg::BPU_RST);
    foreach (walker_pos[i]) walker_pos[i] = 0;
    foreach (hist_count[i]) hist_count[i] = '0;
    energy_acc = 0;
    energy_sq_acc = '0;
    accept_cnt = '0;
    step_cnt = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_saturation();
    test_config_extremes();
    test_random(200);
    tx_idle_pct = 68;
    rx_idle_pct = 25;
    random_config();
    test_random(200);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_config();
    test_random(200);

    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    step_result_t want;
    step_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t result transaction with no expectation waiting", $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        got.accepted = m_tdata[0];
        got.position = m_tdata[24:1];
        got.local_energy = m_tdata[56:25];
        got.bin_index = m_tdata[64:57];
        got.bin_hit = m_tdata[65];
        got.bin_count = m_tdata[97:66];
        got.energy_sum = m_tdata[161:98];
        got.energy_sq_sum = m_tdata[224:162];
        got.accept_count = m_tdata[256:225];
        got.step_count = m_tdata[288:257];
        if (got.accepted != want.accepted)
          report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
        if (got.position != want.position)
          report_mismatch("position", 64'(got.position), 64'(want.position));
        if (got.local_energy != want.local_energy)
          report_mismatch("local_energy", 64'(got.local_energy), 64'(want.local_energy));
        if (got.bin_index != want.bin_index)
          report_mismatch("bin_index", 64'(got.bin_index), 64'(want.bin_index));
        if (got.bin_hit != want.bin_hit)
          report_mismatch("bin_hit", 64'(got.bin_hit), 64'(want.bin_hit));
        if (got.bin_count != want.bin_count)
          report_mismatch("bin_count", 64'(got.bin_count), 64'(want.bin_count));
        if (got.energy_sum != want.energy_sum)
          report_mismatch("energy_sum", got.energy_sum, want.energy_sum);
        if (got.energy_sq_sum != want.energy_sq_sum)
          report_mismatch("energy_sq_sum", 64'(got.energy_sq_sum),
                          64'(want.energy_sq_sum));
        if (got.accept_count != want.accept_count)
          report_mismatch("accept_count", 64'(got.accept_count), 64'(want.accept_count));
        if (got.step_count != want.step_count)
          report_mismatch("step_count", 64'(got.step_count), 64'(want.step_count));
      end
    end
  end

  // Watchdog: a long stretch with no transaction on either side means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mws_pkg.sv
hw/rtl/mws_exp_unit.sv
hw/rtl/mws_accum.sv
hw/rtl/metropolis_walker_step.sv
tb/tb_metropolis_walker_step.sv
